/* rtl/tccw_pkg.sv */
// Shared constants for the text console character writer.
// Screen geometry, field widths, character codes, reset values, function codes and register indexes.
// No dependencies.
`default_nettype none

package tccw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Port field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 2 * BYTE_W;

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ERR   = 8'h45;

    // Register reset values
    localparam logic [BYTE_W-1:0] RESET_DEFAULT_ATTR = 8'd15;
    localparam logic [BYTE_W-1:0] RESET_ERROR_ATTR   = 8'd244;

    // Function codes
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic REG_DEFAULT_ATTR = 1'b0;
    localparam logic REG_ERROR_ATTR   = 1'b1;

endpackage

`default_nettype wire

/* rtl/text_console_char_writer.sv */
// Text console character writer: screen store, cursor and control sequencer.
// Depends on tccw_pkg for widths, character codes and function codes.
`default_nettype none

// Keeps a COLUMNS x ROWS screen of {char, attr} cells in one synchronous RAM
// (one write port, one read port, registered read) plus a cursor. After reset
// a clearing pass fills the screen with spaces before the first transaction
// is taken; configuration writes are taken at any time. A put that does not
// scroll, an off-screen put or read, and an unused function code complete
// directly from the idle state; a read waits in ST_READ for the registered
// RAM data; a clear writes one cell per cycle; a put that scrolls then copies
// one cell per cycle through the RAM's read and write ports. One transaction
// is in flight at a time.
module text_console_char_writer #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [tccw_pkg::BYTE_W-1:0] cfg_data,
    // input channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  func,
    input  wire logic [tccw_pkg::BYTE_W-1:0] ch,
    input  wire logic [tccw_pkg::BYTE_W-1:0] attr,
    input  wire logic [tccw_pkg::COL_W-1:0]  col,
    input  wire logic [tccw_pkg::ROW_W-1:0]  row,
    input  wire logic                        at_cursor,
    // output channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tccw_pkg::BYTE_W-1:0]      cell_char,
    output logic [tccw_pkg::BYTE_W-1:0]      cell_attr,
    output logic [tccw_pkg::COL_W-1:0]       cursor_col,
    output logic [tccw_pkg::ROW_W-1:0]       cursor_row,
    output logic                             scrolled,
    output logic                             range_error
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int CR_W   = $clog2(ROWS);
    localparam int BW     = tccw_pkg::BYTE_W;
    localparam int CW     = tccw_pkg::COL_W;
    localparam int RW     = tccw_pkg::ROW_W;
    localparam int CELL_W = tccw_pkg::CELL_W;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } state_t;

    // Control and payload registers
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                init_reg, init_next;
    logic [BW-1:0]       fill_attr_reg, fill_attr_next;
    logic [CW-1:0]       cur_col_reg, cur_col_next;
    logic [CR_W-1:0]     cur_row_reg, cur_row_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_dst_reg, pend_dst_next;
    logic                pend_zero_reg, pend_zero_next;
    logic [BW-1:0]       default_attr_reg;
    logic [BW-1:0]       error_attr_reg;
    logic                out_valid_reg, out_valid_next;
    logic [BW-1:0]       out_char_reg, out_char_next;
    logic [BW-1:0]       out_attr_reg, out_attr_next;
    logic [CW-1:0]       out_col_reg, out_col_next;
    logic [CR_W-1:0]     out_row_reg, out_row_next;
    logic                out_scr_reg, out_scr_next;
    logic                out_err_reg, out_err_next;

    // Screen RAM
    logic [CELL_W-1:0]   screen_mem [CELLS];
    logic [CELL_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    // Decode of the incoming transaction
    logic                accept;
    logic [CW-1:0]       base_col;
    logic [CR_W-1:0]     base_row;
    logic                off;
    logic [ADDR_W-1:0]   pos;
    logic [BW-1:0]       attr_eff;
    logic [CR_W:0]       nrow;
    logic [CW-1:0]       ncol;
    logic                need_scroll;

    assign in_ready    = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;

    assign out_valid   = out_valid_reg;
    assign cell_char   = out_char_reg;
    assign cell_attr   = out_attr_reg;
    assign cursor_col  = out_col_reg;
    assign cursor_row  = RW'(out_row_reg);
    assign scrolled    = out_scr_reg;
    assign range_error = out_err_reg;

    // Target cell and off-screen check
    always_comb
    begin
        off      = !at_cursor && ((32'(col) >= COLUMNS) || (32'(row) >= ROWS));
        base_col = at_cursor ? cur_col_reg : col;
        base_row = at_cursor ? cur_row_reg : CR_W'(row);
        pos      = ADDR_W'(ADDR_W'(base_row) * ADDR_W'(COLUMNS) + ADDR_W'(base_col));
        attr_eff = (attr == '0) ? default_attr_reg : attr;
    end

    // Cursor after a put
    always_comb
    begin
        nrow = {1'b0, base_row};
        ncol = base_col;
        if (ch == tccw_pkg::CHAR_NL)
        begin
            nrow = {1'b0, base_row} + 1'b1;
            ncol = '0;
        end
        else if (ch != tccw_pkg::CHAR_BS)
        begin
            if (base_col == CW'(COLUMNS - 1))
            begin
                nrow = {1'b0, base_row} + 1'b1;
                ncol = '0;
            end
            else
            begin
                ncol = base_col + 1'b1;
            end
        end
        need_scroll = (nrow == (CR_W + 1)'(ROWS));
    end

    // Sequencer next state, RAM port control and result staging
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        init_next      = init_reg;
        fill_attr_next = fill_attr_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        pend_next      = pend_reg;
        pend_dst_next  = pend_dst_reg;
        pend_zero_next = pend_zero_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_scr_next   = out_scr_reg;
        out_err_next   = out_err_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[ADDR_W-1:0];
        mem_wdata      = {tccw_pkg::CHAR_SPACE, fill_attr_reg};
        mem_raddr      = pos;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // Fill every cell with a space, one per cycle
            ST_FILL:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                    if (!init_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = '0;
                        out_attr_next  = '0;
                        out_col_next   = cur_col_reg;
                        out_row_next   = cur_row_reg;
                        out_scr_next   = 1'b0;
                        out_err_next   = 1'b0;
                    end
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    // default result: no cell data, cursor as it stands
                    out_char_next = '0;
                    out_attr_next = '0;
                    out_col_next  = cur_col_reg;
                    out_row_next  = cur_row_reg;
                    out_scr_next  = 1'b0;
                    out_err_next  = 1'b0;
                    case (func)
                        tccw_pkg::FUNC_PUT:
                        begin
                            if (off)
                            begin
                                // error marker at the last cell
                                mem_we         = 1'b1;
                                mem_waddr      = ADDR_W'(CELLS - 1);
                                mem_wdata      = {tccw_pkg::CHAR_ERR, error_attr_reg};
                                out_err_next   = 1'b1;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                if (ch != tccw_pkg::CHAR_NL)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = pos;
                                    mem_wdata = {(ch == tccw_pkg::CHAR_BS) ?
                                                 tccw_pkg::CHAR_SPACE : ch, attr_eff};
                                end
                                cur_col_next = ncol;
                                if (need_scroll)
                                begin
                                    cur_row_next = CR_W'(ROWS - 1);
                                    cnt_next     = '0;
                                    pend_next    = 1'b0;
                                    state_next   = ST_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next   = nrow[CR_W-1:0];
                                    out_col_next   = ncol;
                                    out_row_next   = nrow[CR_W-1:0];
                                    out_valid_next = 1'b1;
                                end
                            end
                        end
                        tccw_pkg::FUNC_READ:
                        begin
                            if (off)
                            begin
                                out_err_next   = 1'b1;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        tccw_pkg::FUNC_CLEAR:
                        begin
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            fill_attr_next = default_attr_reg;
                            cnt_next       = '0;
                            state_next     = ST_FILL;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // RAM data for the read is now registered
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_char_next  = rd_data_reg[CELL_W-1:BW];
                out_attr_next  = rd_data_reg[BW-1:0];
                out_col_next   = cur_col_reg;
                out_row_next   = cur_row_reg;
                out_scr_next   = 1'b0;
                out_err_next   = 1'b0;
                state_next     = ST_IDLE;
            end

            // Scroll: read cell i+COLUMNS, write it to cell i in the next cycle;
            // the last row gets zeros through the same write stage
            ST_SCROLL:
            begin
                mem_we    = pend_reg;
                mem_waddr = pend_dst_reg;
                mem_wdata = pend_zero_reg ? '0 : rd_data_reg;
                if (cnt_reg < CNT_W'(CELLS))
                begin
                    pend_next      = 1'b1;
                    pend_dst_next  = cnt_reg[ADDR_W-1:0];
                    pend_zero_next = (cnt_reg >= CNT_W'(CELLS - COLUMNS));
                    mem_raddr      = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
                    cnt_next       = cnt_reg + 1'b1;
                end
                else
                begin
                    pend_next      = 1'b0;
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                    out_attr_next  = '0;
                    out_col_next   = cur_col_reg;
                    out_row_next   = cur_row_reg;
                    out_scr_next   = 1'b1;
                    out_err_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, cursor, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FILL;
            cnt_reg          <= '0;
            init_reg         <= 1'b1;
            fill_attr_reg    <= tccw_pkg::RESET_DEFAULT_ATTR;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            pend_reg         <= 1'b0;
            pend_dst_reg     <= '0;
            pend_zero_reg    <= 1'b0;
            default_attr_reg <= tccw_pkg::RESET_DEFAULT_ATTR;
            error_attr_reg   <= tccw_pkg::RESET_ERROR_ATTR;
            out_valid_reg    <= 1'b0;
            out_char_reg     <= '0;
            out_attr_reg     <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_scr_reg      <= 1'b0;
            out_err_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            init_reg      <= init_next;
            fill_attr_reg <= fill_attr_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            pend_reg      <= pend_next;
            pend_dst_reg  <= pend_dst_next;
            pend_zero_reg <= pend_zero_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_attr_reg  <= out_attr_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_scr_reg   <= out_scr_next;
            out_err_reg   <= out_err_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tccw_pkg::REG_DEFAULT_ATTR: default_attr_reg <= cfg_data;
                    tccw_pkg::REG_ERROR_ATTR:   error_attr_reg   <= cfg_data;
                    default:                    error_attr_reg   <= error_attr_reg;
                endcase
            end
        end
    end

    // Screen RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= screen_mem[mem_raddr];
    end

endmodule

`default_nettype wire
